[rtl/core/skc_pkg.sv]
// Shared types, codes and byte tables for the stepper keypad controller.
`timescale 1ns / 1ps
package skc_pkg;

    localparam int JOB_DEPTH_DEF = 4;

    localparam logic [1:0] DIR_STOP  = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;

    localparam logic [1:0] KIND_CMD   = 2'd0;
    localparam logic [1:0] KIND_CHAR  = 2'd1;
    localparam logic [1:0] KIND_PHASE = 2'd2;

    localparam logic [7:0] KEY_UP    = 8'h32;
    localparam logic [7:0] KEY_DOWN  = 8'h38;
    localparam logic [7:0] KEY_LEFT  = 8'h34;
    localparam logic [7:0] KEY_RIGHT = 8'h36;
    localparam logic [7:0] KEY_STOP  = 8'h35;

    localparam logic [7:0] LCD_CLEAR  = 8'h01;
    localparam logic [7:0] ASCII_ZERO = 8'h30;

    localparam logic [3:0] SPEED_MIN   = 4'd1;
    localparam logic [3:0] SPEED_MAX   = 4'd9;
    localparam logic [3:0] SPEED_RESET = 4'd5;
    localparam logic [3:0] DELAY_BASE  = 4'd11;

    typedef struct packed {
        logic       is_phase;
        logic [3:0] pattern;
        logic [1:0] dir;
        logic [3:0] speed;
    } t_job;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } t_res;

    function automatic logic [3:0] phase_pat(input logic [1:0] d, input logic [1:0] idx);
        logic [3:0] p;
        p = 4'h0;
        case (idx)
            2'd0: p = 4'hC;
            2'd1: p = (d == DIR_RIGHT) ? 4'h9 : 4'h6;
            2'd2: p = 4'h3;
            2'd3: p = (d == DIR_RIGHT) ? 4'h6 : 4'h9;
            default: p = 4'h0;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] dir_char(input logic [1:0] d, input logic [2:0] k);
        logic [7:0] c;
        c = 8'h20;
        if (d == DIR_RIGHT) begin
            case (k)
                3'd0: c = "R";
                3'd1: c = "I";
                3'd2: c = "G";
                3'd3: c = "H";
                3'd4: c = "T";
                default: c = " ";
            endcase
        end else if (d == DIR_LEFT) begin
            case (k)
                3'd0: c = "L";
                3'd1: c = "E";
                3'd2: c = "F";
                3'd3: c = "T";
                default: c = " ";
            endcase
        end else begin
            case (k)
                3'd0: c = "S";
                3'd1: c = "T";
                3'd2: c = "O";
                3'd3: c = "P";
                default: c = " ";
            endcase
        end
        return c;
    endfunction

    function automatic logic [7:0] speed_char(input logic [2:0] k);
        logic [7:0] c;
        c = 8'h20;
        case (k)
            3'd0: c = "S";
            3'd1: c = "P";
            3'd2: c = "E";
            3'd3: c = "E";
            3'd4: c = "D";
            default: c = "=";
        endcase
        return c;
    endfunction

    // One byte of the display request at position idx.
    function automatic t_res disp_byte(input logic [1:0] d, input logic [3:0] spd,
                                       input logic [3:0] idx);
        t_res       r;
        logic [3:0] dlen;
        logic [3:0] k;
        dlen = (d == DIR_RIGHT) ? 4'd6 : 4'd5;
        r.kind = KIND_CHAR;
        r.last = 1'b0;
        r.data = LCD_CLEAR;
        if (idx == 4'd0) begin
            r.kind = KIND_CMD;
        end else if (idx <= dlen) begin
            k = idx - 4'd1;
            r.data = dir_char(d, k[2:0]);
        end else if (idx <= dlen + 4'd6) begin
            k = idx - dlen - 4'd1;
            r.data = speed_char(k[2:0]);
        end else begin
            r.data = ASCII_ZERO + {4'd0, spd};
            r.last = 1'b1;
        end
        return r;
    endfunction

endpackage

[rtl/core/skc_front.sv]
// Front end: accepts ticks and keys, keeps speed/direction/step timing, issues jobs.
`timescale 1ns / 1ps
module skc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_cmd,
    input  logic [7:0]    i_key_code,
    output logic          o_job_push,
    output skc_pkg::t_job o_job
);
    import skc_pkg::*;

    logic [3:0] r_speed, n_speed;
    logic [1:0] r_dir, n_dir;
    logic [1:0] r_cyc_dir, n_cyc_dir;
    logic [1:0] r_phase, n_phase;
    logic [3:0] r_delay, n_delay;
    logic       job_valid;
    logic [1:0] cd;

    always_comb begin
        n_speed   = r_speed;
        n_dir     = r_dir;
        n_cyc_dir = r_cyc_dir;
        n_phase   = r_phase;
        n_delay   = r_delay;
        job_valid = 1'b0;
        cd        = (r_phase == 2'd0) ? r_dir : r_cyc_dir;
        o_job.is_phase = !i_cmd;
        o_job.pattern  = phase_pat(cd, r_phase);
        if (!i_cmd) begin
            if (r_delay > 4'd1) begin
                n_delay = r_delay - 4'd1;
            end else begin
                n_cyc_dir = cd;
                if (cd == DIR_RIGHT || cd == DIR_LEFT) begin
                    job_valid = 1'b1;
                    n_phase   = r_phase + 2'd1;
                    n_delay   = DELAY_BASE - r_speed;
                end else begin
                    n_delay = 4'd0;
                end
            end
        end else begin
            job_valid = 1'b1;
            case (i_key_code)
                KEY_UP:    if (r_speed < SPEED_MAX) n_speed = r_speed + 4'd1;
                KEY_DOWN:  if (r_speed > SPEED_MIN) n_speed = r_speed - 4'd1;
                KEY_LEFT:  n_dir = DIR_LEFT;
                KEY_RIGHT: n_dir = DIR_RIGHT;
                KEY_STOP:  n_dir = DIR_STOP;
                default:   job_valid = 1'b0;
            endcase
        end
        o_job.dir   = n_dir;
        o_job.speed = n_speed;
    end

    assign o_job_push = i_accept && job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed   <= SPEED_RESET;
            r_dir     <= DIR_STOP;
            r_cyc_dir <= DIR_STOP;
            r_phase   <= 2'd0;
            r_delay   <= 4'd0;
        end else if (i_accept) begin
            r_speed   <= n_speed;
            r_dir     <= n_dir;
            r_cyc_dir <= n_cyc_dir;
            r_phase   <= n_phase;
            r_delay   <= n_delay;
        end
    end

endmodule

[rtl/core/skc_job_fifo.sv]
// Short job queue between front end and back end.
`timescale 1ns / 1ps
module skc_job_fifo #(
    parameter int DEPTH = skc_pkg::JOB_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  skc_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output skc_pkg::t_job o_job
);
    import skc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[rtl/core/skc_back.sv]
// Back end: expands each job into result bytes, one per cycle while the output is popped, into the output register.
`timescale 1ns / 1ps
module skc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_empty,
    input  skc_pkg::t_job i_job,
    output logic          o_job_pop,
    input  logic          i_pop,
    output logic          o_valid,
    output logic [1:0]    o_out_kind,
    output logic [7:0]    o_out_byte,
    output logic          o_last
);
    import skc_pkg::*;

    logic [3:0] r_idx;
    logic       r_valid;
    t_res       r_res;
    t_res       nxt;
    logic       load;

    always_comb begin
        if (i_job.is_phase) begin
            nxt.kind = KIND_PHASE;
            nxt.data = {4'd0, i_job.pattern};
            nxt.last = 1'b1;
        end else begin
            nxt = disp_byte(i_job.dir, i_job.speed, r_idx);
        end
    end

    assign load      = !i_job_empty && (!r_valid || i_pop);
    assign o_job_pop = load && nxt.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 4'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= nxt.last ? 4'd0 : r_idx + 4'd1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= nxt;
        end
    end

    assign o_valid    = r_valid;
    assign o_out_kind = r_res.kind;
    assign o_out_byte = r_res.data;
    assign o_last     = r_res.last;

endmodule

[rtl/core/stepper_keypad_controller_top.sv]
// Top level of the stepper keypad controller.
//   channel | direction | handshake    | payload
//   request | in        | push / full  | i_cmd, i_key_code
//   result  | out       | pop / empty  | o_out_kind, o_out_byte, o_last
// A request can follow every cycle while the job queue has room.
// Results leave at one per cycle while pop is high: a known key press gives 13 or 14 display
// bytes and a step tick at most one pattern; the back end's byte sequencer sets the rate.
// Reset: synchronous; speed 5, direction stop, queues empty.
// A stalled pop holds the output register; full rises once the job queue is full.
`timescale 1ns / 1ps
module stepper_keypad_controller_top #(
    parameter int JOB_DEPTH = skc_pkg::JOB_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic       i_cmd,
    input  logic [7:0] i_key_code,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_out_kind,
    output logic [7:0] o_out_byte,
    output logic       o_last
);
    import skc_pkg::*;

    logic accept;
    logic job_push, job_pop, job_full, job_empty, out_valid;
    t_job job_in, job_out;

    assign accept = push && !job_full;
    assign full   = job_full;
    assign empty  = !out_valid;

    skc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_cmd      (i_cmd),
        .i_key_code (i_key_code),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    skc_job_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (job_pop),
        .o_full  (job_full),
        .o_empty (job_empty),
        .o_job   (job_out)
    );

    skc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_valid     (out_valid),
        .o_out_kind  (o_out_kind),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

endmodule

[rtl/core/skc_checker.sv]
// Port-level assertions for the stepper keypad controller, bound to the top level.
`timescale 1ns / 1ps
module skc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [1:0] o_out_kind,
    input logic [7:0] o_out_byte,
    input logic       o_last
);
    import skc_pkg::*;

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_out_kind == KIND_CMD || o_out_kind == KIND_CHAR
                    || o_out_kind == KIND_PHASE))
        else $error("illegal result kind");

    a_phase_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_kind == KIND_PHASE) |-> (o_last && o_out_byte[7:4] == 4'd0))
        else $error("bad phase result");

    a_cmd_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_kind == KIND_CMD) |-> (o_out_byte == LCD_CLEAR && !o_last))
        else $error("bad display command");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte) && $stable(o_last)))
        else $error("stalled result changed");

endmodule

bind stepper_keypad_controller_top skc_checker u_skc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .o_out_kind (o_out_kind),
    .o_out_byte (o_out_byte),
    .o_last     (o_last)
);

[test/stepper_keypad_controller_top_tb.sv]
// Self-checking testbench for the stepper keypad controller top level.
`timescale 1ns / 1ps
module stepper_keypad_controller_top_tb;
    import skc_pkg::*;

    localparam int N_ITEMS      = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int N_ROWS       = 17;

    typedef struct packed {
        bit         cmd;
        logic [7:0] key;
        logic [7:0] rep;
        bit         typed;
        logic [3:0] n_res;
        logic [7:0] fin;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic       i_cmd = 1'b0;
    logic [7:0] i_key_code = 8'h00;
    logic       empty;
    logic       pop = 1'b0;
    logic [1:0] o_out_kind;
    logic [7:0] o_out_byte;
    logic       o_last;

    // directed opening: key presses, field extremes, speed saturation,
    // direction change and speed change mid-cycle, stop mid-cycle
    t_row opening_rows [0:N_ROWS-1] = '{
        '{1'b1, KEY_STOP,  8'd1, 1'b1, 4'd13, "5"},
        '{1'b0, 8'hFF,     8'd1, 1'b1, 4'd0,  8'h00},
        '{1'b1, 8'h00,     8'd1, 1'b1, 4'd0,  8'h00},
        '{1'b1, 8'hFF,     8'd1, 1'b1, 4'd0,  8'h00},
        '{1'b1, KEY_UP,    8'd4, 1'b0, 4'd0,  8'h00},
        '{1'b1, KEY_UP,    8'd1, 1'b1, 4'd13, "9"},
        '{1'b1, KEY_RIGHT, 8'd1, 1'b1, 4'd14, "9"},
        '{1'b0, 8'h00,     8'd1, 1'b1, 4'd1,  8'h0C},
        '{1'b0, 8'h5A,     8'd2, 1'b0, 4'd0,  8'h00},
        '{1'b1, KEY_LEFT,  8'd1, 1'b1, 4'd13, "9"},
        '{1'b0, 8'hA5,     8'd4, 1'b0, 4'd0,  8'h00},
        '{1'b0, 8'h00,     8'd2, 1'b0, 4'd0,  8'h00},
        '{1'b1, KEY_DOWN,  8'd1, 1'b1, 4'd13, "8"},
        '{1'b1, KEY_STOP,  8'd1, 1'b1, 4'd13, "8"},
        '{1'b0, 8'h0F,     8'd8, 1'b0, 4'd0,  8'h00},
        '{1'b0, 8'hF0,     8'd4, 1'b0, 4'd0,  8'h00},
        '{1'b1, 8'h37,     8'd1, 1'b1, 4'd0,  8'h00}
    };

    logic [7:0] key_pool [0:8] = '{KEY_UP, KEY_UP, KEY_DOWN, KEY_DOWN, KEY_LEFT,
                                   KEY_LEFT, KEY_RIGHT, KEY_RIGHT, KEY_STOP};
    logic [3:0] right_pats [0:3] = '{4'hC, 4'h9, 4'h3, 4'h6};
    logic [3:0] left_pats  [0:3] = '{4'hC, 4'h6, 4'h3, 4'h9};

    // controller state as predicted
    logic [3:0] speed_lvl;
    logic [1:0] dir_now;
    logic [1:0] cyc_dir;
    logic [1:0] phase_idx;
    logic [3:0] step_cnt;

    t_res owed_results [$];

    bit         cur_typed = 1'b0;
    int         cur_n_res = 0;
    logic [7:0] cur_fin = 8'h00;

    bit idle_en = 1'b1;
    bit rx_run = 1'b0;
    bit hold_req = 1'b0;
    int hold_cnt = 0;

    int errors = 0;
    int stall_cycles = 0;
    int n_keys = 0;
    int n_ticks = 0;
    int n_disp = 0;
    int n_phase = 0;

    stepper_keypad_controller_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_cmd      (i_cmd),
        .i_key_code (i_key_code),
        .empty      (empty),
        .pop        (pop),
        .o_out_kind (o_out_kind),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void owe(input logic [1:0] kind, input logic [7:0] data,
                                input logic last);
        t_res r;
        r.kind = kind;
        r.data = data;
        r.last = last;
        owed_results.push_back(r);
    endfunction

    // Advances the predicted controller by one request; returns results owed.
    function automatic int advance_controller(input logic cmd, input logic [7:0] key);
        string      txt;
        logic [3:0] pat;
        int         n;
        n = owed_results.size();
        if (!cmd) begin
            if (step_cnt > 4'd1) begin
                step_cnt = step_cnt - 4'd1;
                return 0;
            end
            if (phase_idx == 2'd0)
                cyc_dir = dir_now;
            if (cyc_dir == DIR_RIGHT) begin
                pat = right_pats[phase_idx];
            end else if (cyc_dir == DIR_LEFT) begin
                pat = left_pats[phase_idx];
            end else begin
                step_cnt = 4'd0;
                return 0;
            end
            phase_idx = phase_idx + 2'd1;
            step_cnt = DELAY_BASE - speed_lvl;
            owe(KIND_PHASE, {4'h0, pat}, 1'b1);
            return 1;
        end
        case (key)
            KEY_UP: begin
                if (speed_lvl < SPEED_MAX)
                    speed_lvl = speed_lvl + 4'd1;
            end
            KEY_DOWN: begin
                if (speed_lvl > SPEED_MIN)
                    speed_lvl = speed_lvl - 4'd1;
            end
            KEY_LEFT:  dir_now = DIR_LEFT;
            KEY_RIGHT: dir_now = DIR_RIGHT;
            KEY_STOP:  dir_now = DIR_STOP;
            default:   return 0;
        endcase
        owe(KIND_CMD, LCD_CLEAR, 1'b0);
        if (dir_now == DIR_LEFT)
            txt = "LEFT ";
        else if (dir_now == DIR_RIGHT)
            txt = "RIGHT ";
        else
            txt = "STOP ";
        txt = {txt, "SPEED="};
        foreach (txt[i])
            owe(KIND_CHAR, txt[i], 1'b0);
        owe(KIND_CHAR, ASCII_ZERO + {4'd0, speed_lvl}, 1'b1);
        return owed_results.size() - n;
    endfunction

    // request intake, result check and watchdog, all sampled at the rising edge
    always @(posedge i_clk) begin
        int   n;
        t_res want;
        bit   moved;
        moved = 1'b0;
        if (i_rst_n && push && !full) begin
            moved = 1'b1;
            if (i_cmd)
                n_keys++;
            else
                n_ticks++;
            n = advance_controller(i_cmd, i_key_code);
            if (cur_typed) begin
                if (n != cur_n_res) begin
                    $error("result count: expected %0d, actual %0d", cur_n_res, n);
                    errors++;
                end else if (n > 0) begin
                    owed_results[owed_results.size() - 1].data = cur_fin;
                end
            end
        end
        if (i_rst_n && pop && !empty) begin
            moved = 1'b1;
            if (o_out_kind == KIND_PHASE)
                n_phase++;
            else
                n_disp++;
            if (owed_results.size() == 0) begin
                $error("unexpected result: out_kind %0d out_byte 0x%02h last %0b",
                       o_out_kind, o_out_byte, o_last);
                errors++;
            end else begin
                want = owed_results.pop_front();
                if (o_out_kind !== want.kind) begin
                    $error("out_kind: expected %0d, actual %0d", want.kind, o_out_kind);
                    errors++;
                end
                if (o_out_byte !== want.data) begin
                    $error("out_byte: expected 0x%02h, actual 0x%02h", want.data, o_out_byte);
                    errors++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, actual %0b", want.last, o_last);
                    errors++;
                end
            end
        end
        stall_cycles = moved ? 0 : stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles, %0d results owed",
                     STALL_LIMIT, owed_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: random pop gaps, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (!rx_run) begin
            pop <= 1'b0;
        end else if (hold_cnt > 0) begin
            pop <= 1'b0;
            hold_cnt = hold_cnt - 1;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = HOLD_CYCLES - 1;
            pop <= 1'b0;
        end else begin
            pop <= !(idle_en && $urandom_range(0, 99) < 34);
        end
    end

    task automatic send_request(input logic cmd, input logic [7:0] key, input bit typed,
                                input int n_res, input logic [7:0] fin);
        @(negedge i_clk);
        while (idle_en && $urandom_range(0, 99) < 34) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_cmd <= cmd;
        i_key_code <= key;
        cur_typed <= typed;
        cur_n_res <= n_res;
        cur_fin <= fin;
        do @(posedge i_clk); while (full);
    endtask

    initial begin
        int         counted;
        int         pick;
        bit         cmd;
        logic [7:0] key;
        bit         held;
        bit         paused;
        speed_lvl = SPEED_RESET;
        dir_now = DIR_STOP;
        cyc_dir = DIR_STOP;
        phase_idx = 2'd0;
        step_cnt = 4'd0;
        counted = 0;
        held = 1'b0;
        paused = 1'b0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        rx_run = 1'b1;

        foreach (opening_rows[r]) begin
            repeat (opening_rows[r].rep)
                send_request(opening_rows[r].cmd, opening_rows[r].key, opening_rows[r].typed,
                             opening_rows[r].n_res, opening_rows[r].fin);
        end

        while (counted < N_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                cmd = 1'b0;
                key = 8'($urandom_range(0, 255));
            end else if (pick < 88) begin
                cmd = 1'b1;
                key = key_pool[$urandom_range(0, 8)];
            end else begin
                cmd = 1'b1;
                key = 8'($urandom_range(0, 255));
            end
            send_request(cmd, key, 1'b0, 0, 8'h00);
            counted++;
            if (counted == 100 && !held) begin
                held = 1'b1;
                hold_req = 1'b1;
            end
            if (counted == 200 && !paused) begin
                paused = 1'b1;
                @(negedge i_clk);
                push <= 1'b0;
                while (owed_results.size() != 0) @(posedge i_clk);
            end
            idle_en = !(counted >= 250 && counted < 330);
        end

        @(negedge i_clk);
        push <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d key presses and %0d ticks, checked %0d display bytes",
                 n_keys, n_ticks, n_disp);
        $display("and %0d step patterns across speed limits, turns and stops mid-cycle",
                 n_phase);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
